FILE: sv/fbmac_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbmac_pkg
// Shared types and codes for the flash block map access checker: request
// and response words, request functions, status codes and register indexes.
// ----------------------------------------------------------------------------
package fbmac_pkg;

  // request functions
  typedef enum logic [1:0] {
    FUNC_READ  = 2'd0,
    FUNC_WRITE = 2'd1,
    FUNC_ERASE = 2'd2,
    FUNC_QUERY = 2'd3
  } func_t;

  // response status codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_DENIED  = 2'd2,
    ST_CLAMPED = 2'd3
  } status_t;

  // configuration register indexes
  localparam logic [2:0] CFG_VOLUME_BASE    = 3'd0;
  localparam logic [2:0] CFG_ACCESS_ENABLES = 3'd1;
  localparam logic [2:0] CFG_MAP_ENTRY_A    = 3'd2;

  // access enable bits
  localparam int EN_READ_BIT  = 0;
  localparam int EN_WRITE_BIT = 1;

  // request word
  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] lba;
    logic [31:0] block_offset;
    logic [31:0] num_bytes;
  } req_t;

  // response word
  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] address;
    logic [31:0] block_length;
    logic [31:0] blocks_remaining;
    logic [31:0] byte_count;
  } rsp_t;

  // map lookup result handed from the lookup stage to the resolve stage
  typedef struct packed {
    req_t        req;
    logic        hit;
    logic [31:0] run_offs;
    logic [31:0] scaled;
    logic [31:0] blk_len;
    logic [31:0] left;
  } lk_t;

endpackage

FILE: sv/fbmac_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbmac_cfg_regs
// Configuration registers and the run table derived from them: start and
// end block of each run, byte offset of each run and the live mask.
// ----------------------------------------------------------------------------
module fbmac_cfg_regs #(
  parameter int MAP_ENTRIES = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_wdata,
  output logic [31:0] volume_base,
  output logic [1:0]  access_enables,
  output logic        live     [MAP_ENTRIES],
  output logic [32+$clog2(MAP_ENTRIES+1)-1:0] run_first [MAP_ENTRIES],
  output logic [32+$clog2(MAP_ENTRIES+1)-1:0] run_last  [MAP_ENTRIES],
  output logic [31:0] run_offs [MAP_ENTRIES],
  output logic [31:0] blk_len  [MAP_ENTRIES]
);
  import fbmac_pkg::*;

  localparam int SW = 32 + $clog2(MAP_ENTRIES + 1);

  logic [31:0] base_r;
  logic [1:0]  en_r;
  logic [63:0] entry_r [MAP_ENTRIES];
  logic [31:0] prod_r  [MAP_ENTRIES];
  logic [63:0] wprod;
  logic        wr;

  logic          live_r  [MAP_ENTRIES];
  logic          live_nxt[MAP_ENTRIES];
  logic [SW-1:0] first_r [MAP_ENTRIES];
  logic [SW-1:0] first_nxt[MAP_ENTRIES];
  logic [SW-1:0] last_r  [MAP_ENTRIES];
  logic [SW-1:0] last_nxt[MAP_ENTRIES];
  logic [31:0]   offs_r  [MAP_ENTRIES];
  logic [31:0]   offs_nxt[MAP_ENTRIES];

  assign cfg_ready = 1'b1;
  assign wr        = cfg_valid & cfg_ready;

  // bytes covered by a whole run, taken from the word being written
  assign wprod = cfg_wdata[63:32] * cfg_wdata[31:0];

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= '0;
      en_r   <= '0;
      for (int i = 0; i < MAP_ENTRIES; i++) begin
        entry_r[i] <= '0;
        prod_r[i]  <= '0;
      end
    end else if (wr) begin
      if (cfg_index == CFG_VOLUME_BASE) begin
        base_r <= cfg_wdata[31:0];
      end
      if (cfg_index == CFG_ACCESS_ENABLES) begin
        en_r <= cfg_wdata[1:0];
      end
      for (int i = 0; i < MAP_ENTRIES; i++) begin
        if (cfg_index == 3'(CFG_MAP_ENTRY_A + i)) begin
          entry_r[i] <= cfg_wdata;
          prod_r[i]  <= wprod[31:0];
        end
      end
    end
  end

  // run table: prefix sums over the map, an entry with a zero block count or a zero block length ends the map
  always_comb begin
    logic          alive;
    logic [SW-1:0] acc;
    logic [31:0]   oacc;
    alive = 1'b1;
    acc   = '0;
    oacc  = '0;
    for (int i = 0; i < MAP_ENTRIES; i++) begin
      alive        = alive && (entry_r[i][63:32] != '0) && (entry_r[i][31:0] != '0);
      live_nxt[i]  = alive;
      first_nxt[i] = acc;
      offs_nxt[i]  = oacc;
      acc          = acc + SW'(entry_r[i][63:32]);
      last_nxt[i]  = acc;
      oacc         = oacc + prod_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAP_ENTRIES; i++) begin
        live_r[i] <= 1'b0;
      end
    end else begin
      for (int i = 0; i < MAP_ENTRIES; i++) begin
        live_r[i] <= live_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAP_ENTRIES; i++) begin
      first_r[i] <= first_nxt[i];
      last_r[i]  <= last_nxt[i];
      offs_r[i]  <= offs_nxt[i];
    end
  end

  // outputs
  assign volume_base    = base_r;
  assign access_enables = en_r;
  always_comb begin
    for (int i = 0; i < MAP_ENTRIES; i++) begin
      live[i]      = live_r[i];
      run_first[i] = first_r[i];
      run_last[i]  = last_r[i];
      run_offs[i]  = offs_r[i];
      blk_len[i]   = entry_r[i][31:0];
    end
  end

endmodule

FILE: sv/fbmac_lookup.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbmac_lookup
// Finds the run holding the requested block, scales the block index inside
// the run by the block length and registers the result.
// ----------------------------------------------------------------------------
module fbmac_lookup #(
  parameter int MAP_ENTRIES = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               req_valid,
  input  fbmac_pkg::req_t    req,
  input  logic               live      [MAP_ENTRIES],
  input  logic [32+$clog2(MAP_ENTRIES+1)-1:0] run_first [MAP_ENTRIES],
  input  logic [32+$clog2(MAP_ENTRIES+1)-1:0] run_last  [MAP_ENTRIES],
  input  logic [31:0]        run_offs  [MAP_ENTRIES],
  input  logic [31:0]        blk_len   [MAP_ENTRIES],
  output logic               lk_valid,
  output fbmac_pkg::lk_t     lk
);
  import fbmac_pkg::*;

  localparam int SW = 32 + $clog2(MAP_ENTRIES + 1);

  logic          hit;
  logic [SW-1:0] sel_first;
  logic [SW-1:0] sel_last;
  logic [31:0]   sel_offs;
  logic [31:0]   sel_len;
  logic [SW-1:0] lba_ext;
  logic [31:0]   idx;
  logic [63:0]   scaled;
  logic [SW-1:0] left;
  logic          v_r;
  lk_t           lk_r;
  lk_t           lk_nxt;

  assign lba_ext = SW'(req.lba);

  // run search, first live run that holds the block wins
  always_comb begin
    hit       = 1'b0;
    sel_first = '0;
    sel_last  = '0;
    sel_offs  = '0;
    sel_len   = '0;
    for (int i = 0; i < MAP_ENTRIES; i++) begin
      if (!hit && live[i] && (lba_ext >= run_first[i]) && (lba_ext < run_last[i])) begin
        hit       = 1'b1;
        sel_first = run_first[i];
        sel_last  = run_last[i];
        sel_offs  = run_offs[i];
        sel_len   = blk_len[i];
      end
    end
  end

  // block index inside the run, its byte offset and blocks left
  assign idx    = req.lba - sel_first[31:0];
  assign scaled = idx * sel_len;
  assign left   = sel_last - lba_ext;

  always_comb begin
    lk_nxt          = '0;
    lk_nxt.req      = req;
    lk_nxt.hit      = hit;
    lk_nxt.run_offs = sel_offs;
    lk_nxt.scaled   = scaled[31:0];
    lk_nxt.blk_len  = sel_len;
    lk_nxt.left     = left[31:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    lk_r <= lk_nxt;
  end

  assign lk_valid = v_r;
  assign lk       = lk_r;

endmodule

FILE: sv/fbmac_resolve.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbmac_resolve
// Forms the flash address, applies the access checks in order, clamps the
// byte count at the block end and registers the response word.
// ----------------------------------------------------------------------------
module fbmac_resolve (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            lk_valid,
  input  fbmac_pkg::lk_t  lk,
  input  logic [31:0]     volume_base,
  input  logic [1:0]      access_enables,
  output logic            out_valid,
  output fbmac_pkg::rsp_t out_rsp
);
  import fbmac_pkg::*;

  logic [31:0] blk_start;
  logic        en;
  logic [32:0] reach;
  rsp_t        rsp_nxt;
  rsp_t        rsp_r;
  logic        v_r;

  // block start in flash, wraps at 32 bits
  assign blk_start = volume_base + lk.run_offs + lk.scaled;

  assign en    = (lk.req.func == FUNC_READ) ? access_enables[EN_READ_BIT]
                                            : access_enables[EN_WRITE_BIT];
  assign reach = {1'b0, lk.req.num_bytes} + {1'b0, lk.req.block_offset};

  // checks and result fields
  always_comb begin
    rsp_nxt                  = '0;
    rsp_nxt.status           = ST_OK;
    rsp_nxt.address          = blk_start;
    rsp_nxt.block_length     = lk.blk_len;
    rsp_nxt.blocks_remaining = lk.left;
    case (lk.req.func)
      FUNC_READ, FUNC_WRITE: begin
        if ((lk.req.num_bytes == '0) || !lk.hit) begin
          rsp_nxt.status = ST_INVALID;
        end else if (!en) begin
          rsp_nxt.status = ST_DENIED;
        end else if (lk.req.block_offset > lk.blk_len) begin
          rsp_nxt.status = ST_INVALID;
        end else begin
          rsp_nxt.address    = blk_start + lk.req.block_offset;
          rsp_nxt.byte_count = lk.req.num_bytes;
          if (reach > {1'b0, lk.blk_len}) begin
            rsp_nxt.byte_count = lk.blk_len - lk.req.block_offset;
            rsp_nxt.status     = ST_CLAMPED;
          end
        end
      end
      FUNC_ERASE: begin
        if (!access_enables[EN_WRITE_BIT]) begin
          rsp_nxt.status = ST_DENIED;
        end else if (!lk.hit) begin
          rsp_nxt.status = ST_INVALID;
        end
      end
      default: begin
        if (!lk.hit) begin
          rsp_nxt.status = ST_INVALID;
        end
      end
    endcase
    // failed requests carry nothing else
    if ((rsp_nxt.status == ST_INVALID) || (rsp_nxt.status == ST_DENIED)) begin
      rsp_nxt.address          = '0;
      rsp_nxt.block_length     = '0;
      rsp_nxt.blocks_remaining = '0;
      rsp_nxt.byte_count       = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= lk_valid;
    end
  end

  always_ff @(posedge clk) begin
    rsp_r <= rsp_nxt;
  end

  assign out_valid = v_r;
  assign out_rsp   = rsp_r;

endmodule

FILE: sv/flash_block_map_access_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flash_block_map_access_checker
// Translates a logical block request into a flash address over a small
// block map and checks it against the volume's read and write enables.
// ----------------------------------------------------------------------------
// A request is taken on every cycle with start high; busy never rises, so
// requests may follow one another in consecutive cycles. Each request gives
// exactly one response word, shown for a single cycle with out_valid high.
// The receiver cannot stall the response, so it must take the word in that
// cycle. The response passes through the input register, the map search
// with its 32 by 32 multiply, and the address and check stage. A register
// write takes effect for requests started from the next cycle on; write
// only while no request is in flight.
module flash_block_map_access_checker #(
  parameter int MAP_ENTRIES = 4
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  fbmac_pkg::req_t in_req,
  output logic            out_valid,
  output fbmac_pkg::rsp_t out_rsp,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [2:0]      cfg_index,
  input  logic [63:0]     cfg_wdata
);
  import fbmac_pkg::*;

  localparam int SW = 32 + $clog2(MAP_ENTRIES + 1);

  logic          in_v_r;
  req_t          in_r;
  logic [31:0]   volume_base;
  logic [1:0]    access_enables;
  logic          live      [MAP_ENTRIES];
  logic [SW-1:0] run_first [MAP_ENTRIES];
  logic [SW-1:0] run_last  [MAP_ENTRIES];
  logic [31:0]   run_offs  [MAP_ENTRIES];
  logic [31:0]   blk_len   [MAP_ENTRIES];
  logic          lk_valid;
  lk_t           lk;

  assign busy = 1'b0;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else begin
      in_v_r <= start & ~busy;
    end
  end

  always_ff @(posedge clk) begin
    in_r <= in_req;
  end

  // configuration and run table
  fbmac_cfg_regs #(
    .MAP_ENTRIES(MAP_ENTRIES)
  ) u_cfg (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .volume_base   (volume_base),
    .access_enables(access_enables),
    .live          (live),
    .run_first     (run_first),
    .run_last      (run_last),
    .run_offs      (run_offs),
    .blk_len       (blk_len)
  );

  // map search
  fbmac_lookup #(
    .MAP_ENTRIES(MAP_ENTRIES)
  ) u_lookup (
    .clk      (clk),
    .rst_n    (rst_n),
    .req_valid(in_v_r),
    .req      (in_r),
    .live     (live),
    .run_first(run_first),
    .run_last (run_last),
    .run_offs (run_offs),
    .blk_len  (blk_len),
    .lk_valid (lk_valid),
    .lk       (lk)
  );

  // address, checks and response register
  fbmac_resolve u_resolve (
    .clk           (clk),
    .rst_n         (rst_n),
    .lk_valid      (lk_valid),
    .lk            (lk),
    .volume_base   (volume_base),
    .access_enables(access_enables),
    .out_valid     (out_valid),
    .out_rsp       (out_rsp)
  );

`ifndef SYNTHESIS
  // every accepted request gets a response
  a_latency_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##3 out_valid)
    else $error("response missing for accepted request");

  // no response without a request
  a_latency_none: assert property (@(posedge clk) disable iff (!rst_n)
    !(start && !busy) |-> ##3 !out_valid)
    else $error("response without request");

  // failed requests carry zero fields
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && ((out_rsp.status == ST_INVALID) || (out_rsp.status == ST_DENIED)))
      |-> (out_rsp.address == '0) && (out_rsp.block_length == '0) &&
          (out_rsp.blocks_remaining == '0) && (out_rsp.byte_count == '0))
    else $error("failed response carries data");

  // the byte count never runs past the block
  a_count_in_block: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_rsp.byte_count <= out_rsp.block_length))
    else $error("byte count beyond block length");
`endif

endmodule
